@@ rtl/core/cbt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants for the cubic Bezier tessellator.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int CoordFracBits = 4;
  localparam int CoordW        = 16 + CoordFracBits;
  localparam int SegW          = 6;
  localparam int MinSegments   = 2;
  localparam int MaxSegments   = 63;
  localparam int TBits         = 16;
  localparam int TW            = TBits + 1;
  localparam int DivSteps      = TW;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t            start_x;
    coord_t            start_y;
    coord_t            ctrl1_x;
    coord_t            ctrl1_y;
    coord_t            ctrl2_x;
    coord_t            ctrl2_y;
    coord_t            end_x;
    coord_t            end_y;
    logic [SegW-1:0]   segment_count;
  } in_item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } out_item_t;

  // curve with clamped count, plus t step = 65536 / n as quotient and remainder
  typedef struct packed {
    in_item_t         curve;
    logic [TBits-1:0] step_q;
    logic [SegW-1:0]  step_r;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

@@ rtl/core/cbt_front.sv @@
// ----------------------------------------------------------------------------
// cbt_front
// Accepts curves, clamps the segment count and finds the t step with a
// bit-serial divider.
// ----------------------------------------------------------------------------
module cbt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbt_pkg::in_item_t in_item_i,
  input  logic              push_ready_i,
  output cbt_pkg::push_t    push_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;
  localparam int CntW = $clog2(cbt_pkg::DivSteps);

  logic [1:0]                 state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [cbt_pkg::SegW-1:0]   rem_q, rem_d;
  logic [cbt_pkg::TW-1:0]     quo_q, quo_d;
  cbt_pkg::in_item_t          item_q, item_d;
  logic [cbt_pkg::SegW-1:0]   n_clamp;
  logic [cbt_pkg::SegW:0]     rem_sh;
  logic                       ge;
  logic                       accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_item_i.segment_count < cbt_pkg::SegW'(cbt_pkg::MinSegments)) begin
      n_clamp = cbt_pkg::SegW'(cbt_pkg::MinSegments);
    end else if (in_item_i.segment_count > cbt_pkg::SegW'(cbt_pkg::MaxSegments)) begin
      n_clamp = cbt_pkg::SegW'(cbt_pkg::MaxSegments);
    end else begin
      n_clamp = in_item_i.segment_count;
    end
  end

  // dividend is 2^TBits: only the first bit shifted in is a one
  assign rem_sh = {rem_q, (cnt_q == '0)};
  assign ge     = rem_sh >= {1'b0, item_q.segment_count};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    item_d  = item_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          item_d               = in_item_i;
          item_d.segment_count = n_clamp;
          cnt_d                = '0;
          rem_d                = '0;
          quo_d                = '0;
          state_d              = StDiv;
        end
      end
      StDiv: begin
        rem_d = ge ? cbt_pkg::SegW'(rem_sh - {1'b0, item_q.segment_count})
                   : cbt_pkg::SegW'(rem_sh);
        quo_d = {quo_q[cbt_pkg::TW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(cbt_pkg::DivSteps - 1)) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (push_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    item_q <= item_d;
  end

  assign push_o.valid        = (state_q == StPush);
  assign push_o.entry.curve  = item_q;
  assign push_o.entry.step_q = quo_q[cbt_pkg::TBits-1:0];
  assign push_o.entry.step_r = rem_q;

endmodule

@@ rtl/core/cbt_queue.sv @@
// ----------------------------------------------------------------------------
// cbt_queue
// Two-entry queue of prepared curves between front and back.
// ----------------------------------------------------------------------------
module cbt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbt_pkg::push_t  push_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output cbt_pkg::entry_t pop_entry_o,
  input  logic            pop_i
);

  cbt_pkg::entry_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

endmodule

@@ rtl/core/cbt_back.sv @@
// ----------------------------------------------------------------------------
// cbt_back
// Steps t over a curve and evaluates one point per cycle while the output is not
// stalled, in a four-stage Bernstein pipeline with round and saturate.
// ----------------------------------------------------------------------------
module cbt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cbt_pkg::entry_t    q_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbt_pkg::out_item_t out_item_o
);

  localparam int TW   = cbt_pkg::TW;
  localparam int PW   = 2 * TW;
  localparam int WW   = TW + 3;
  localparam int MW   = WW + cbt_pkg::CoordW;
  localparam int AccW = MW + 2;
  localparam int SegW = cbt_pkg::SegW;
  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;
  localparam logic [TW-1:0] TOne = TW'(1) << cbt_pkg::TBits;
  localparam logic [PW:0]   PHalf = (PW+1)'(1) << (cbt_pkg::TBits - 1);
  localparam logic signed [AccW-1:0] AHalf = AccW'(1) << (cbt_pkg::TBits - 1);
  localparam logic signed [AccW-1:0] SatHi = AccW'((1 << (cbt_pkg::CoordW - 1)) - 1);
  localparam logic signed [AccW-1:0] SatLo = -AccW'(1 << (cbt_pkg::CoordW - 1));

  function automatic logic [TW-1:0] qround(input logic [PW-1:0] x);
    logic [PW:0] s;
    s = {1'b0, x} + PHalf;
    return TW'(s >> cbt_pkg::TBits);
  endfunction

  function automatic cbt_pkg::coord_t rnd_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] r;
    r = (acc + AHalf) >>> cbt_pkg::TBits;
    if (r > SatHi) return SatHi[cbt_pkg::CoordW-1:0];
    if (r < SatLo) return SatLo[cbt_pkg::CoordW-1:0];
    return r[cbt_pkg::CoordW-1:0];
  endfunction

  logic              state_q;
  cbt_pkg::entry_t   cur_q;
  logic [SegW-1:0]   i_q, r_q;
  logic [TW-1:0]     t_q;
  logic              en, issue, last_i;
  logic [SegW:0]     r_sum;
  logic              wrap;

  logic              v1_q, v2_q, v3_q, ov_q;
  logic              l1_q, l2_q, l3_q;
  logic [TW-1:0]     t1_q, u1_q, u0;
  logic [PW-1:0]     tt1_q, uu1_q;
  logic [TW-1:0]     t2, u2;
  logic [PW-1:0]     a2_q, b2_q, c2_q, d2_q;
  logic signed [WW-1:0] w0, w1, w2, w3;
  logic signed [MW-1:0] px_q [4];
  logic signed [MW-1:0] py_q [4];
  logic signed [AccW-1:0] accx, accy;
  cbt_pkg::out_item_t out_q;

  assign en     = !ov_q || !out_stall_i;
  assign issue  = (state_q == StRun) && en;
  assign last_i = (i_q == cur_q.curve.segment_count);
  assign pop_o  = (state_q == StIdle) && q_valid_i && !v1_q && !v2_q && !v3_q;
  assign r_sum  = {1'b0, r_q} + {1'b0, cur_q.step_r};
  assign wrap   = r_sum >= {1'b0, cur_q.curve.segment_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q <= StRun;
        i_q     <= '0;
      end else if (issue) begin
        if (last_i) state_q <= StIdle;
        i_q <= i_q + 1'b1;
      end
      if (en) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        ov_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_entry_i;
      t_q   <= '0;
      r_q   <= q_entry_i.curve.segment_count >> 1;
    end else if (issue) begin
      t_q <= t_q + TW'(cur_q.step_q) + TW'(wrap);
      r_q <= wrap ? SegW'(r_sum - {1'b0, cur_q.curve.segment_count}) : SegW'(r_sum);
    end
  end

  assign u0 = TOne - t_q;
  assign t2 = qround(tt1_q);
  assign u2 = qround(uu1_q);
  assign w0 = WW'(qround(a2_q));
  assign w1 = WW'(3 * WW'(qround(b2_q)));
  assign w2 = WW'(3 * WW'(qround(c2_q)));
  assign w3 = WW'(qround(d2_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q  <= t_q;
      u1_q  <= u0;
      tt1_q <= t_q * t_q;
      uu1_q <= u0 * u0;
      l1_q  <= last_i;

      a2_q  <= u2 * u1_q;
      b2_q  <= u2 * t1_q;
      c2_q  <= u1_q * t2;
      d2_q  <= t2 * t1_q;
      l2_q  <= l1_q;

      px_q[0] <= w0 * cur_q.curve.start_x;
      px_q[1] <= w1 * cur_q.curve.ctrl1_x;
      px_q[2] <= w2 * cur_q.curve.ctrl2_x;
      px_q[3] <= w3 * cur_q.curve.end_x;
      py_q[0] <= w0 * cur_q.curve.start_y;
      py_q[1] <= w1 * cur_q.curve.ctrl1_y;
      py_q[2] <= w2 * cur_q.curve.ctrl2_y;
      py_q[3] <= w3 * cur_q.curve.end_y;
      l3_q    <= l2_q;

      out_q.point_x    <= rnd_sat(accx);
      out_q.point_y    <= rnd_sat(accy);
      out_q.last_point <= l3_q;
    end
  end

  assign accx = AccW'(px_q[0]) + AccW'(px_q[1]) + AccW'(px_q[2]) + AccW'(px_q[3]);
  assign accy = AccW'(py_q[0]) + AccW'(py_q[1]) + AccW'(py_q[2]) + AccW'(py_q[3]);

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/core/cubic_bezier_tessellator.sv @@
// Path from curve accept to its first point: the bit-serial divider, push,
// queue pop and the four-stage evaluation pipe; then one point per cycle while
// the output is not stalled. Each curve gives n+1 points. The front accepts,
// divides and pushes the next curve while the back still works on earlier ones;
// the back pops it only after issuing every point and draining its pipe.
// Reset: rst_ni asynchronous active low clears all control state.
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator
// Splits cubic Bezier curves into n+1 points in Q16.4 fixed point.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cbt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbt_pkg::out_item_t out_item_o
);

  cbt_pkg::push_t  push;
  logic            push_ready;
  logic            q_valid;
  cbt_pkg::entry_t q_entry;
  logic            pop;

  cbt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_ready_i (push_ready),
    .push_o       (push)
  );

  cbt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_entry_o  (q_entry),
    .pop_i        (pop)
  );

  cbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/core/cbt_checker.sv @@
// ----------------------------------------------------------------------------
// cbt_checker
// Port-level checks for the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module cbt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input cbt_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cbt_pkg::out_item_t out_item_o
);

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("front not busy after accept");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##15 in_stall_o)
    else $error("front released before divider finished");

endmodule

bind cubic_bezier_tessellator cbt_checker u_cbt_checker (.*);

@@ tb/cubic_bezier_tessellator_tb.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator_tb
// Drives curves through the tessellator with random gaps and stalls, predicts
// every point in fixed point and checks each output item in order.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator_tb;

  localparam int WatchdogLimit = 20000;
  localparam int LongHold      = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  cbt_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  cbt_pkg::out_item_t out_item_o;

  cbt_pkg::in_item_t  curve_q[$];
  cbt_pkg::out_item_t point_q[$];
  int        err_cnt;
  int        idle_cycles;
  bit        stim_done;
  bit        hold_rx;
  bit        pause_tx;
  int        tx_wait;
  int        rx_wait;
  int        hold_left;
  int        sent_cnt;
  logic      in_acc_q;
  logic      out_acc_q;

  cubic_bezier_tessellator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic longint unsigned round_q16(longint unsigned a, longint unsigned b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  function automatic cbt_pkg::coord_t bezier_axis(
      longint unsigned w0, longint unsigned w1, longint unsigned w2, longint unsigned w3,
      cbt_pkg::coord_t p0, cbt_pkg::coord_t p1, cbt_pkg::coord_t p2, cbt_pkg::coord_t p3);
    longint acc;
    longint r;
    acc = longint'(w0) * longint'(p0) + longint'(w1) * longint'(p1)
        + longint'(w2) * longint'(p2) + longint'(w3) * longint'(p3);
    r = (acc + 64'sd32768) >>> 16;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return cbt_pkg::coord_t'(r[cbt_pkg::CoordW-1:0]);
  endfunction

  task automatic predict_points(input cbt_pkg::in_item_t c);
    int unsigned n;
    longint unsigned t, u, t2, u2, w0, w1, w2, w3;
    cbt_pkg::out_item_t p;
    n = c.segment_count;
    if (n < cbt_pkg::MinSegments) n = cbt_pkg::MinSegments;
    if (n > cbt_pkg::MaxSegments) n = cbt_pkg::MaxSegments;
    for (int unsigned i = 0; i <= n; i++) begin
      t  = (longint'(i) * 65536 + n / 2) / n;
      u  = 65536 - t;
      t2 = round_q16(t, t);
      u2 = round_q16(u, u);
      w0 = round_q16(u2, u);
      w1 = 3 * round_q16(u2, t);
      w2 = 3 * round_q16(u, t2);
      w3 = round_q16(t2, t);
      p.point_x = bezier_axis(w0, w1, w2, w3, c.start_x, c.ctrl1_x, c.ctrl2_x, c.end_x);
      p.point_y = bezier_axis(w0, w1, w2, w3, c.start_y, c.ctrl1_y, c.ctrl2_y, c.end_y);
      p.last_point = (i == n);
      point_q.push_back(p);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  function automatic cbt_pkg::coord_t rand_coord(int mode);
    case (mode)
      0: return cbt_pkg::coord_t'(20'h80000);
      1: return cbt_pkg::coord_t'(20'h7ffff);
      2: return cbt_pkg::coord_t'($urandom_range(0, 255) - 128);
      default: return cbt_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic cbt_pkg::in_item_t rand_curve(int seg_max);
    cbt_pkg::in_item_t c;
    int m;
    m = $urandom_range(0, 9);
    c.start_x = rand_coord(m < 1 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.start_y = rand_coord(m < 1 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.ctrl1_x = rand_coord(m < 2 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.ctrl1_y = rand_coord(m < 2 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.ctrl2_x = rand_coord(m < 2 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.ctrl2_y = rand_coord(m < 2 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.end_x   = rand_coord(m < 1 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.end_y   = rand_coord(m < 1 ? $urandom_range(0, 1) : $urandom_range(2, 3));
    c.segment_count = ($urandom_range(0, 19) == 0) ? 6'd63 : 6'($urandom_range(0, seg_max));
    return c;
  endfunction

  initial begin
    cbt_pkg::in_item_t c;
    err_cnt = 0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    // directed: endpoints, extremes, small and large counts
    for (int k = 0; k < 20; k++) begin
      c.start_x = (k % 2) ? cbt_pkg::coord_t'(20'h7ffff) : cbt_pkg::coord_t'(20'h80000);
      c.start_y = (k % 3 == 0) ? cbt_pkg::coord_t'(20'h7ffff) : cbt_pkg::coord_t'(20'h80000);
      c.ctrl1_x = (k % 4 < 2) ? cbt_pkg::coord_t'(20'h7ffff) : cbt_pkg::coord_t'(20'h80000);
      c.ctrl1_y = (k % 5 < 2) ? cbt_pkg::coord_t'(20'h80000) : cbt_pkg::coord_t'(20'h7ffff);
      c.ctrl2_x = (k % 2) ? cbt_pkg::coord_t'(20'h80000) : cbt_pkg::coord_t'(20'h7ffff);
      c.ctrl2_y = (k % 3 == 1) ? cbt_pkg::coord_t'(20'h80000) : cbt_pkg::coord_t'(20'h7ffff);
      c.end_x   = (k % 4 == 3) ? cbt_pkg::coord_t'(20'h80000) : cbt_pkg::coord_t'(20'h7ffff);
      c.end_y   = (k % 2) ? cbt_pkg::coord_t'(20'h7ffff) : cbt_pkg::coord_t'(20'h80000);
      case (k)
        0: c.segment_count = 6'd0;
        1: c.segment_count = 6'd1;
        2: c.segment_count = 6'd2;
        3: c.segment_count = 6'd63;
        4: c.segment_count = 6'd3;
        5: c.segment_count = 6'h2a;
        6: c.segment_count = 6'h15;
        default: c.segment_count = 6'($urandom_range(0, 63));
      endcase
      if (k >= 12) c = rand_curve(63);
      if (k == 16) c = '0;
      curve_q.push_back(c);
    end
    for (int k = 0; k < 250; k++) curve_q.push_back(rand_curve(12));
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (curve_q.size() == 0 && !in_valid_i);
    stim_done = 1'b1;
  end

  // handshakes seen at the rising edge, used by the falling-edge drivers
  always @(posedge clk_i) begin
    in_acc_q  <= rst_ni && in_valid_i && !in_stall_o;
    out_acc_q <= rst_ni && out_valid_o && !out_stall_i;
  end

  // predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_points(in_item_i);
    end
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      tx_wait    <= 0;
      sent_cnt   <= 0;
      pause_tx   <= 1'b0;
    end else if (!in_valid_i || in_acc_q) begin
      if (in_acc_q && sent_cnt == 180) begin
        pause_tx   <= 1'b1;
        in_valid_i <= 1'b0;
      end else if (pause_tx && point_q.size() > 0) begin
        in_valid_i <= 1'b0;
      end else if (tx_wait > 0) begin
        tx_wait    <= tx_wait - 1;
        in_valid_i <= 1'b0;
      end else if (curve_q.size() > 0) begin
        pause_tx   <= 1'b0;
        in_item_i  <= curve_q.pop_front();
        in_valid_i <= 1'b1;
        sent_cnt   <= sent_cnt + 1;
        tx_wait    <= $urandom_range(0, 3);
      end else begin
        pause_tx   <= 1'b0;
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (point_q.size() == 0) begin
        report_mismatch("unexpected point", out_item_o.point_x, 0);
      end else begin
        if (out_item_o.point_x !== point_q[0].point_x)
          report_mismatch("point_x", out_item_o.point_x, point_q[0].point_x);
        if (out_item_o.point_y !== point_q[0].point_y)
          report_mismatch("point_y", out_item_o.point_y, point_q[0].point_y);
        if (out_item_o.last_point !== point_q[0].last_point)
          report_mismatch("last_point", out_item_o.last_point, point_q[0].last_point);
        void'(point_q.pop_front());
      end
    end
  end

  // receiver stalls, with one long hold-off while the sender keeps offering
  always @(negedge clk_i or negedge rst_ni) begin : rx_proc
    int w;
    if (!rst_ni) begin
      rx_wait     <= 0;
      hold_left   <= 0;
      hold_rx     <= 1'b0;
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (sent_cnt == 60 && !hold_rx) begin
      hold_rx     <= 1'b1;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else if (out_acc_q) begin
      w = $urandom_range(0, 3);
      rx_wait     <= w;
      out_stall_i <= (w != 0);
    end else if (rx_wait > 0) begin
      rx_wait     <= rx_wait - 1;
      out_stall_i <= (rx_wait > 1);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (point_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && point_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
